FILE: hw/rtl/lbw_pkg.sv
package lbw_pkg;

    localparam int MAX_NODES = 16;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int POS_W     = 16;
    localparam int ID_W      = 8;
    localparam int WT_W      = 17;
    localparam int CMD_W     = 2;

    localparam logic [WT_W-1:0] WEIGHT_ONE = WT_W'(65536);

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    // table read address source
    localparam logic [1:0] RD_IDX    = 2'd0;
    localparam logic [1:0] RD_IDX_M1 = 2'd1;
    localparam logic [1:0] RD_LAST   = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [ID_W-1:0]  id;
    } t_entry;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       rd_en;
        logic [1:0] rd_src;
        logic       add_shift;
        logic       add_place;
        logic       rem_step;
        logic       rem_finish;
        logic       ev_cap0;
        logic       ev_check;
        logic       ev_scan;
        logic       ev_div_cap;
        logic       emit;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic idx_zero;
        logic pos_gt;
        logic rem_end;
        logic count_zero;
        logic ev_interior;
        logic scan_hit;
        logic div_done;
        logic emit_last;
    } t_dp_status;

endpackage

FILE: hw/rtl/linear_blend_weights_1d_core.sv
// Linear blend-weight table, one dimension, up to 16 nodes kept sorted by position.
// Command channel: an item (i_command, i_position, i_node_id) is taken at a rising
// edge with start high and busy low. Commands: add node, remove node by id,
// evaluate a query position, clear the table.
// Result channel: an evaluate emits one weight per stored node in table order,
// each on o_node_id_res / o_weight / o_last for exactly one cycle with o_strobe
// high; o_last marks the final weight. The receiver cannot stall, so results are
// sent one per cycle once emission starts. Empty table: no results.
// Per command (n = nodes stored):
//   clear: busy stays low.
//   add: each stored node above the new position is read and shifted up
//   one place, then the node is placed; a full table is left unchanged.
//   remove: all n entries are read, and the ones kept are written back in order.
//   evaluate: nothing on an empty table; an end case gives weight one to the
//   end node; an interior query scans for the bracketing nodes and runs one
//   pass of the radix-2 divider (17 quotient bits). Each result passes
//   through the r_pv and r_strobe registers after emission starts.
// Reset (i_rst_n, synchronous) empties the table and returns to idle.
module linear_blend_weights_1d_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [lbw_pkg::CMD_W-1:0]          i_command,
    input  logic signed [lbw_pkg::POS_W-1:0]   i_position,
    input  logic [lbw_pkg::ID_W-1:0]           i_node_id,
    output logic                               o_strobe,
    output logic [lbw_pkg::ID_W-1:0]           o_node_id_res,
    output logic [lbw_pkg::WT_W-1:0]           o_weight,
    output logic                               o_last
);

    lbw_pkg::t_dp_cmd    dp_cmd;
    lbw_pkg::t_dp_status dp_status;

    lbw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_status  (dp_status),
        .o_busy    (busy),
        .o_cmd     (dp_cmd)
    );

    lbw_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_position    (i_position),
        .i_node_id     (i_node_id),
        .o_status      (dp_status),
        .o_strobe      (o_strobe),
        .o_node_id_res (o_node_id_res),
        .o_weight      (o_weight),
        .o_last        (o_last)
    );

endmodule

FILE: hw/rtl/lbw_div.sv
module lbw_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [lbw_pkg::POS_W-1:0]       i_dividend,
    input  logic [lbw_pkg::POS_W-1:0]       i_divisor,
    output logic                            o_done,
    output logic [lbw_pkg::WT_W-1:0]        o_quot
);

    localparam int W = lbw_pkg::POS_W;

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [$clog2(W+1)-1:0]       r_cnt, n_cnt;
    logic [W-1:0]                 r_rem, n_rem;
    logic [W-1:0]                 r_div, n_div;
    logic [lbw_pkg::WT_W-1:0]     r_quot, n_quot;

    logic         init_ge;
    logic [W:0]   rem2;
    logic         step_ge;
    logic [W:0]   step_sub;

    assign init_ge  = (i_dividend >= i_divisor);
    assign rem2     = {r_rem, 1'b0};
    assign step_ge  = (rem2 >= {1'b0, r_div});
    assign step_sub = rem2 - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = ($clog2(W+1))'(W);
            n_div  = i_divisor;
            n_rem  = init_ge ? (i_dividend - i_divisor) : i_dividend;
            n_quot = {{(lbw_pkg::WT_W-1){1'b0}}, init_ge};
        end else if (r_busy) begin
            n_rem  = step_ge ? step_sub[W-1:0] : rem2[W-1:0];
            n_quot = {r_quot[lbw_pkg::WT_W-2:0], step_ge};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == ($clog2(W+1))'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: hw/rtl/lbw_datapath.sv
module lbw_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lbw_pkg::t_dp_cmd               i_cmd,
    input  logic signed [lbw_pkg::POS_W-1:0] i_position,
    input  logic [lbw_pkg::ID_W-1:0]       i_node_id,
    output lbw_pkg::t_dp_status            o_status,
    output logic                           o_strobe,
    output logic [lbw_pkg::ID_W-1:0]       o_node_id_res,
    output logic [lbw_pkg::WT_W-1:0]       o_weight,
    output logic                           o_last
);

    localparam int IW = lbw_pkg::IDX_W;
    localparam int CW = lbw_pkg::CNT_W;
    localparam int PW = lbw_pkg::POS_W;

    lbw_pkg::t_entry r_mem [lbw_pkg::MAX_NODES];
    lbw_pkg::t_entry r_rdata;

    logic signed [PW-1:0]      r_pos;
    logic [lbw_pkg::ID_W-1:0]  r_id;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_idx;
    logic [CW-1:0]             r_w;
    logic signed [PW-1:0]      r_plo;
    logic [IW-1:0]             r_aidx;
    logic                      r_bv;
    logic [lbw_pkg::WT_W-1:0]  r_aw;
    logic [lbw_pkg::WT_W-1:0]  r_bw;
    logic                      r_pv;
    logic [IW-1:0]             r_pidx;
    logic                      r_strobe;
    logic [lbw_pkg::ID_W-1:0]  r_out_id;
    logic [lbw_pkg::WT_W-1:0]  r_out_wt;
    logic                      r_out_last;

    logic signed [PW-1:0]      rd_pos;
    logic [CW-1:0]             idx_m1;
    logic [CW-1:0]             cnt_m1;
    logic [IW-1:0]             raddr;
    logic                      we;
    logic [IW-1:0]             waddr;
    lbw_pkg::t_entry           wdata;
    logic signed [PW:0]        diff_full;
    logic signed [PW:0]        range_full;
    logic                      div_done;
    logic [lbw_pkg::WT_W-1:0]  div_quot;
    logic                      low_end;
    logic [IW-1:0]             pidx_b;
    logic [lbw_pkg::WT_W-1:0]  pipe_wt;

    assign rd_pos = $signed(r_rdata.pos);
    assign idx_m1 = r_idx - 1'b1;
    assign cnt_m1 = r_count - 1'b1;

    always_comb begin
        case (i_cmd.rd_src)
            lbw_pkg::RD_IDX:    raddr = r_idx[IW-1:0];
            lbw_pkg::RD_IDX_M1: raddr = idx_m1[IW-1:0];
            lbw_pkg::RD_LAST:   raddr = cnt_m1[IW-1:0];
            default:            raddr = r_idx[IW-1:0];
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_idx[IW-1:0];
        wdata = r_rdata;
        if (i_cmd.add_shift) begin
            we = 1'b1;
        end else if (i_cmd.add_place) begin
            we    = 1'b1;
            wdata = '{pos: r_pos, id: r_id};
        end else if (i_cmd.rem_step && (r_rdata.id != r_id)) begin
            we    = 1'b1;
            waddr = r_w[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[raddr];
        end
    end

    assign diff_full  = {r_pos[PW-1], r_pos} - {r_plo[PW-1], r_plo};
    assign range_full = {rd_pos[PW-1], rd_pos} - {r_plo[PW-1], r_plo};
    assign low_end    = (r_count == CW'(1)) || (r_pos <= r_plo);

    lbw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.ev_scan && (rd_pos >= r_pos)),
        .i_dividend (diff_full[PW-1:0]),
        .i_divisor  (range_full[PW-1:0]),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.add_place) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.rem_finish) begin
            r_count <= r_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos <= i_position;
            r_id  <= i_node_id;
            r_w   <= '0;
            r_idx <= (i_cmd.rd_src == lbw_pkg::RD_IDX_M1) ? r_count : '0;
        end
        if (i_cmd.add_shift) begin
            r_idx <= idx_m1;
        end
        if (i_cmd.rem_step) begin
            r_idx <= r_idx + 1'b1;
            if (r_rdata.id != r_id) begin
                r_w <= r_w + 1'b1;
            end
        end
        if (i_cmd.ev_cap0) begin
            r_plo <= rd_pos;
        end
        if (i_cmd.ev_check) begin
            if (o_status.ev_interior) begin
                r_idx <= CW'(1);
            end else begin
                r_idx  <= '0;
                r_aidx <= low_end ? '0 : cnt_m1[IW-1:0];
                r_aw   <= lbw_pkg::WEIGHT_ONE;
                r_bv   <= 1'b0;
            end
        end
        if (i_cmd.ev_scan) begin
            if (rd_pos >= r_pos) begin
                r_aidx <= idx_m1[IW-1:0];
                r_bv   <= 1'b1;
            end else begin
                r_plo <= rd_pos;
                r_idx <= r_idx + 1'b1;
            end
        end
        if (i_cmd.ev_div_cap) begin
            r_aw  <= lbw_pkg::WEIGHT_ONE - div_quot;
            r_bw  <= div_quot;
            r_idx <= '0;
        end
        if (i_cmd.emit) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    assign pidx_b = r_aidx + 1'b1;

    always_comb begin
        if (r_pidx == r_aidx) begin
            pipe_wt = r_aw;
        end else if (r_bv && (r_pidx == pidx_b)) begin
            pipe_wt = r_bw;
        end else begin
            pipe_wt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_pv     <= i_cmd.emit;
            r_strobe <= r_pv;
        end
        r_pidx <= r_idx[IW-1:0];
        if (r_pv) begin
            r_out_id   <= r_rdata.id;
            r_out_wt   <= pipe_wt;
            r_out_last <= ({1'b0, r_pidx} == cnt_m1);
        end
    end

    assign o_status.full        = (r_count == CW'(lbw_pkg::MAX_NODES));
    assign o_status.idx_zero    = (r_idx == '0);
    assign o_status.pos_gt      = (rd_pos > r_pos);
    assign o_status.rem_end     = (r_idx == r_count);
    assign o_status.count_zero  = (r_count == '0);
    assign o_status.ev_interior = !low_end && (r_pos < rd_pos);
    assign o_status.scan_hit    = (rd_pos >= r_pos);
    assign o_status.div_done    = div_done;
    assign o_status.emit_last   = (r_idx == cnt_m1);

    assign o_strobe      = r_strobe;
    assign o_node_id_res = r_out_id;
    assign o_weight      = r_out_wt;
    assign o_last        = r_out_last;

endmodule

FILE: hw/rtl/lbw_ctrl.sv
module lbw_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lbw_pkg::CMD_W-1:0]   i_command,
    input  lbw_pkg::t_dp_status         i_status,
    output logic                        o_busy,
    output lbw_pkg::t_dp_cmd            o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ADD_RD = 4'd1;
    localparam logic [3:0] S_ADD_WR = 4'd2;
    localparam logic [3:0] S_REM_RD = 4'd3;
    localparam logic [3:0] S_REM_WR = 4'd4;
    localparam logic [3:0] S_EV_RD0 = 4'd5;
    localparam logic [3:0] S_EV_RDL = 4'd6;
    localparam logic [3:0] S_EV_CHK = 4'd7;
    localparam logic [3:0] S_EV_SRD = 4'd8;
    localparam logic [3:0] S_EV_SCK = 4'd9;
    localparam logic [3:0] S_EV_DIV = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;
    localparam logic [3:0] S_DRAIN  = 4'd12;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_src = lbw_pkg::RD_IDX;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (i_command)
                        lbw_pkg::CMD_ADD: begin
                            o_cmd.rd_src = lbw_pkg::RD_IDX_M1;
                            n_state = S_ADD_RD;
                        end
                        lbw_pkg::CMD_REMOVE: n_state = S_REM_RD;
                        lbw_pkg::CMD_EVAL:   n_state = S_EV_RD0;
                        lbw_pkg::CMD_CLEAR:  o_cmd.clear = 1'b1;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD: begin
                if (i_status.full) begin
                    n_state = S_IDLE;
                end else if (i_status.idx_zero) begin
                    o_cmd.add_place = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = lbw_pkg::RD_IDX_M1;
                    n_state = S_ADD_WR;
                end
            end
            S_ADD_WR: begin
                if (i_status.pos_gt) begin
                    o_cmd.add_shift = 1'b1;
                    n_state = S_ADD_RD;
                end else begin
                    o_cmd.add_place = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_REM_RD: begin
                if (i_status.rem_end) begin
                    o_cmd.rem_finish = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_REM_WR;
                end
            end
            S_REM_WR: begin
                o_cmd.rem_step = 1'b1;
                n_state = S_REM_RD;
            end
            S_EV_RD0: begin
                if (i_status.count_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_EV_RDL;
                end
            end
            S_EV_RDL: begin
                o_cmd.ev_cap0 = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_src  = lbw_pkg::RD_LAST;
                n_state = S_EV_CHK;
            end
            S_EV_CHK: begin
                o_cmd.ev_check = 1'b1;
                n_state = i_status.ev_interior ? S_EV_SRD : S_EMIT;
            end
            S_EV_SRD: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_EV_SCK;
            end
            S_EV_SCK: begin
                o_cmd.ev_scan = 1'b1;
                n_state = i_status.scan_hit ? S_EV_DIV : S_EV_SRD;
            end
            S_EV_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.ev_div_cap = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit  = 1'b1;
                o_cmd.rd_en = 1'b1;
                if (i_status.emit_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
